### hw/rtl/hfa_pkg.sv
// Shared types, sizes and codes for the hole fit allocator.
package hfa_pkg;

	// Table geometry.
	localparam int HOLES     = 16;
	localparam int SIZE_BITS = 32;
	localparam int IDX_W     = (HOLES > 1) ? $clog2(HOLES) : 1;
	localparam int CNT_W     = $clog2(HOLES + 1);

	// Fixed field widths of the ports.
	localparam int SLOT_W     = 4;
	localparam int AMOUNT_W   = 32;
	localparam int POLICY_W   = 2;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 1'd1;

	// Placement policies.
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
	localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

	// Operation codes of an input word.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic commit;
	} hfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic scan_done;
		logic out_free;
	} hfa_sts_t;

endpackage

### hw/rtl/hole_fit_allocator.sv
// Top level of the hole fit allocator.
// Keeps sixteen free hole sizes and places requests by first, best, worst or next fit.
// A load word writes one hole. An allocate word is first accepted; with best or worst
// fit the n holes in use are then scanned one by one through the single table read port
// and comparator, and last the chosen hole is updated and the result registered. First
// and next fit end the scan at the first hole that fits. With no hole in use an allocate
// skips the scan. Words are not taken while an allocation is in progress, and the final
// step waits while an earlier result has not yet been taken. The hole table resets to
// all zero with no clearing pass. Configuration writes are always accepted.
module hole_fit_allocator
	import hfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [AMOUNT_W-1:0]   amount,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  granted,
	output logic [SLOT_W-1:0]     chosen_hole,
	output logic [AMOUNT_W-1:0]   left_over
);

	hfa_cmd_t cmd;
	hfa_sts_t sts;

	// Configuration words are taken in any cycle.
	assign cfg_ready = 1'b1;

	hfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.slot        (slot),
		.amount      (amount),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.granted     (granted),
		.chosen_hole (chosen_hole),
		.left_over   (left_over)
	);

endmodule

### hw/rtl/hfa_ctrl.sv
// Controller state machine of the hole fit allocator.
module hfa_ctrl
	import hfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     operation,
	output logic     in_ready,
	input  hfa_sts_t sts,
	output hfa_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// A new word is taken only between allocations.
	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = sts.empty ? ST_COMMIT : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/hfa_dp.sv
// Datapath of the hole fit allocator: hole table, scan unit and result register.
module hfa_dp
	import hfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [AMOUNT_W-1:0]   amount,
	input  hfa_cmd_t              cmd,
	output hfa_sts_t              sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  granted,
	output logic [SLOT_W-1:0]     chosen_hole,
	output logic [AMOUNT_W-1:0]   left_over
);

	logic [POLICY_W-1:0]  policy_q;
	logic [COUNT_W-1:0]   hole_count_q;
	logic [SIZE_BITS-1:0] table_q [HOLES];
	logic [IDX_W-1:0]     next_start_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     k_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] pick_size_q;
	logic                 out_valid_q;
	logic                 granted_q;
	logic [SLOT_W-1:0]    chosen_q;
	logic [AMOUNT_W-1:0]  left_q;

	logic [CNT_W-1:0]     n;
	logic [IDX_W-1:0]     base;
	logic [SIZE_BITS-1:0] cur_size;
	logic                 fits;
	logic                 take;
	logic                 early_stop;
	logic [SIZE_BITS-1:0] remain;

	// Holes in use, capped at the table depth.
	assign n = (CNT_W'(hole_count_q) > CNT_W'(HOLES)) ? CNT_W'(HOLES) : CNT_W'(hole_count_q);

	// Next fit starts at the last hole granted; other policies start at zero.
	assign base = (policy_q == POL_NEXT && CNT_W'(next_start_q) < n) ? next_start_q : '0;

	// One table entry is examined per scan cycle.
	assign cur_size = table_q[idx_q];
	assign fits     = (cur_size >= req_q);

	always_comb begin
		take = 1'b0;
		if (fits) begin
			priority if (!found_q) begin
				take = 1'b1;
			end else if (policy_q == POL_BEST) begin
				take = (cur_size < pick_size_q);
			end else if (policy_q == POL_WORST) begin
				take = (cur_size > pick_size_q);
			end else begin
				take = 1'b0;
			end
		end
	end

	// First and next fit stop at the first hole that fits.
	assign early_stop = fits && (policy_q == POL_FIRST || policy_q == POL_NEXT);
	assign remain     = pick_size_q - req_q;

	assign sts.empty     = (n == '0);
	assign sts.scan_done = (k_q == n - CNT_W'(1)) || early_stop;
	assign sts.out_free  = !out_valid_q || out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= POL_FIRST;
			hole_count_q <= COUNT_W'(HOLES);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FIT_POLICY: policy_q     <= cfg_data[POLICY_W-1:0];
				REG_HOLE_COUNT: hole_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Hole table and next fit pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HOLES; i++) begin
				table_q[i] <= '0;
			end
			next_start_q <= '0;
		end else if (cmd.load) begin
			if (32'(slot) < HOLES) begin
				table_q[slot[IDX_W-1:0]] <= SIZE_BITS'(amount);
			end
			next_start_q <= '0;
		end else if (cmd.commit && found_q) begin
			table_q[pick_q] <= remain;
			if (policy_q == POL_NEXT) begin
				next_start_q <= pick_q;
			end
		end
	end

	// Scan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (cmd.step && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= SIZE_BITS'(amount);
			idx_q <= base;
			k_q   <= '0;
		end else if (cmd.step) begin
			idx_q <= (CNT_W'(idx_q) + CNT_W'(1) == n) ? '0 : idx_q + IDX_W'(1);
			k_q   <= k_q + CNT_W'(1);
			if (take) begin
				pick_q      <= idx_q;
				pick_size_q <= cur_size;
			end
		end
	end

	// Result register toward the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q <= found_q;
			chosen_q  <= found_q ? SLOT_W'(pick_q) : '0;
			left_q    <= found_q ? AMOUNT_W'(remain) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = granted_q;
	assign chosen_hole = chosen_q;
	assign left_over   = left_q;

	// A result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// The held candidate always covers the request.
	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !cmd.start) |-> (pick_size_q >= req_q))
		else $error("candidate hole smaller than request");

	// A refused request reports zeros.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !granted_q) |-> (chosen_q == '0 && left_q == '0))
		else $error("refused request carries data");

	// A grant shrinks the chosen hole by the request.
	a_table_update: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && found_q) |=> (table_q[$past(pick_q)] == $past(remain)))
		else $error("hole table not updated on grant");

endmodule
